// File: rtl/lru_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU page replacement unit.
// Depends on nothing; every other file refers to it by scoped names.
package lru_pkg;

    localparam int PID_W   = 4;
    localparam int PC_W    = 12;
    localparam int LIMIT_W = 6;
    localparam int MAP_W   = 32;
    localparam int PAGE_W  = 5;
    localparam int STAMP_W = 32;
    localparam int EXT_W   = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_REDUCE,
        ST_EMIT
    } lru_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } lru_red_ctrl_t;

endpackage

// File: rtl/lru_stamp_mem.sv
`timescale 1ns / 1ps
// Timestamp memory: one row of page stamps per process, with a registered read port.
// Uses lru_pkg; rows that were never written read as zero through per-row valid bits.
module lru_stamp_mem #(
    parameter int ROWS  = 16,
    parameter int PAGES = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
    output logic [PAGES*lru_pkg::STAMP_W-1:0]     rd_data,
    input  logic                                  wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
    input  logic [PAGES*lru_pkg::STAMP_W-1:0]     wr_data
);

    localparam int ROW_BITS = PAGES * lru_pkg::STAMP_W;

    logic [ROW_BITS-1:0] stamp_ram [ROWS];
    logic [ROW_BITS-1:0] rd_q_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_ram[wr_row] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= stamp_ram[rd_row];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_row] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_row];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

// File: rtl/lru_age_reduce.sv
`timescale 1ns / 1ps
// Iterative maximum-age search: candidates are loaded once, then halved one tree level per step.
// Uses lru_pkg for the control struct; ties keep the lower page index.
module lru_age_reduce #(
    parameter int PAGES = 32
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  lru_pkg::lru_red_ctrl_t                         ctrl,
    input  logic [(2**$clog2(PAGES))-1:0]                  elig_in,
    input  logic [(2**$clog2(PAGES))*lru_pkg::STAMP_W-1:0] age_in,
    output logic                                           best_valid,
    output logic [$clog2(PAGES)-1:0]                       best_index
);

    localparam int IDX_W = $clog2(PAGES);
    localparam int NUM   = 2 ** IDX_W;
    localparam int HALF  = NUM / 2;

    logic                         cvalid_reg [NUM];
    logic [lru_pkg::STAMP_W-1:0]  cage_reg   [NUM];
    logic [IDX_W-1:0]             cidx_reg   [NUM];
    logic                         cvalid_next [NUM];
    logic [lru_pkg::STAMP_W-1:0]  cage_next   [NUM];
    logic [IDX_W-1:0]             cidx_next   [NUM];

    always_comb
    begin
        for (int i = 0; i < NUM; i++)
        begin
            cvalid_next[i] = cvalid_reg[i];
            cage_next[i]   = cage_reg[i];
            cidx_next[i]   = cidx_reg[i];
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < NUM; i++)
            begin
                cvalid_next[i] = elig_in[i];
                cage_next[i]   = age_in[i*lru_pkg::STAMP_W +: lru_pkg::STAMP_W];
                cidx_next[i]   = IDX_W'(i);
            end
        end
        else if (ctrl.step)
        begin
            for (int i = 0; i < HALF; i++)
            begin
                if (cvalid_reg[2*i+1] &&
                    (!cvalid_reg[2*i] || (cage_reg[2*i+1] > cage_reg[2*i])))
                begin
                    cvalid_next[i] = 1'b1;
                    cage_next[i]   = cage_reg[2*i+1];
                    cidx_next[i]   = cidx_reg[2*i+1];
                end
                else
                begin
                    cvalid_next[i] = cvalid_reg[2*i];
                    cage_next[i]   = cage_reg[2*i];
                    cidx_next[i]   = cidx_reg[2*i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM; i++)
            begin
                cvalid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM; i++)
            begin
                cvalid_reg[i] <= cvalid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM; i++)
        begin
            cage_reg[i] <= cage_next[i];
            cidx_reg[i] <= cidx_next[i];
        end
    end

    assign best_valid = cvalid_reg[0];
    assign best_index = cidx_reg[0];

endmodule

// File: rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
// Top level of the LRU page replacement unit: handshake, sequencer, tick and stamp update.
// Uses lru_pkg, lru_stamp_mem and lru_age_reduce.
// One access is taken at a time. The accepted beat's process row is read from the stamp
// memory at the accepting edge, stamps are written back and ages formed in the next cycle,
// and the result is then loaded into the output register from the emit state. The result
// becomes valid in the same cycle that the input is ready again. For a valid process and
// an in-range page, a miss with no free frame also runs the victim search in the reduce
// state, which halves the candidate set once per cycle until one candidate is left. A
// result that waits on out_ready holds the next access back before its own output load.
// The output register lets a new beat be accepted while the previous result still waits.
// The stamp store reads as zero after reset with no clearing pass.
module lru_page_replacement_unit #(
    parameter int PROCESSES         = 16,
    parameter int PAGES_PER_PROCESS = 32,
    parameter int PAGE_BYTES        = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lru_pkg::PID_W-1:0]    process_id,
    input  logic [lru_pkg::PC_W-1:0]     program_counter,
    input  logic [lru_pkg::LIMIT_W-1:0]  pages_in_use,
    input  logic [lru_pkg::MAP_W-1:0]    resident_map,
    input  logic                         frame_free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lru_pkg::PAGE_W-1:0]   wanted_page,
    output logic                         page_miss,
    output logic                         evict_valid,
    output logic [lru_pkg::PAGE_W-1:0]   victim_page
);

    localparam int ROW_W    = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int IDX_W    = $clog2(PAGES_PER_PROCESS);
    localparam int NUM      = 2 ** IDX_W;
    localparam int LEVELS   = IDX_W;
    localparam int STEP_W   = $clog2(LEVELS + 1);
    localparam int SW       = lru_pkg::STAMP_W;
    localparam int ROW_BITS = PAGES_PER_PROCESS * SW;
    localparam int DIV_SH   = lru_pkg::PC_W + $clog2(PAGE_BYTES);
    localparam longint DIV_MUL = ((64'd1 << DIV_SH) + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int MUL_W    = lru_pkg::PC_W + 2;
    localparam int PROD_W   = lru_pkg::PC_W + MUL_W;

    lru_pkg::lru_state_t     state_reg;
    lru_pkg::lru_state_t     state_next;
    lru_pkg::lru_red_ctrl_t  red_ctrl;

    logic [lru_pkg::PID_W-1:0]   pid_reg;
    logic [lru_pkg::PC_W-1:0]    pc_reg;
    logic [lru_pkg::LIMIT_W-1:0] limit_reg;
    logic [lru_pkg::MAP_W-1:0]   map_reg;
    logic                        free_reg;
    logic [SW-1:0]               tick_reg;
    logic [SW-1:0]               tick_next;
    logic [STEP_W-1:0]           step_cnt_reg;
    logic [STEP_W-1:0]           step_cnt_next;
    logic                        search_reg;
    logic                        search_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [lru_pkg::PAGE_W-1:0]  want_out_reg;
    logic                        miss_out_reg;
    logic                        evict_out_reg;
    logic [lru_pkg::PAGE_W-1:0]  victim_out_reg;
    logic                        load_out;

    logic                        accept;
    logic [PROD_W-1:0]           div_prod;
    logic [lru_pkg::PC_W-1:0]    want_full;
    logic                        want_in_map;
    logic                        miss;
    logic                        page_ok;
    logic                        proc_ok;
    logic                        need_search;

    logic                        mem_rd_en;
    logic                        mem_wr_en;
    logic [ROW_BITS-1:0]         rd_data;
    logic [ROW_BITS-1:0]         wr_data;
    logic [NUM*SW-1:0]           rd_ext;
    logic [lru_pkg::EXT_W-1:0]   map_ext;
    logic [NUM-1:0]              elig;
    logic [NUM*SW-1:0]           ages;
    logic                        best_valid;
    logic [IDX_W-1:0]            best_index;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == lru_pkg::ST_IDLE);

    assign div_prod    = PROD_W'(pc_reg) * PROD_W'(DIV_MUL);
    assign want_full   = lru_pkg::PC_W'(div_prod >> DIV_SH);
    assign want_in_map = (want_full < lru_pkg::PC_W'(lru_pkg::MAP_W));
    assign miss        = !(want_in_map && map_reg[want_full[lru_pkg::PAGE_W-1:0]]);
    assign page_ok     = want_in_map && ({20'd0, want_full} < 32'(PAGES_PER_PROCESS));
    assign proc_ok     = ({28'd0, pid_reg} < 32'(PROCESSES));
    assign need_search = proc_ok && page_ok && miss && !free_reg;

    assign rd_ext  = (NUM*SW)'(rd_data);
    assign map_ext = lru_pkg::EXT_W'(map_reg);

    always_comb
    begin
        for (int p = 0; p < NUM; p++)
        begin
            ages[p*SW +: SW] = tick_reg - rd_ext[p*SW +: SW];
            elig[p] = (p < PAGES_PER_PROCESS) && (lru_pkg::LIMIT_W'(p) < limit_reg) &&
                      (lru_pkg::PC_W'(p) != want_full) && map_ext[p];
        end
        for (int p = 0; p < PAGES_PER_PROCESS; p++)
        begin
            if (page_ok && (want_full == lru_pkg::PC_W'(p)))
            begin
                wr_data[p*SW +: SW] = tick_reg;
            end
            else
            begin
                wr_data[p*SW +: SW] = rd_data[p*SW +: SW];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        tick_next      = tick_reg;
        step_cnt_next  = step_cnt_reg;
        search_next    = search_reg;
        red_ctrl       = '0;
        mem_rd_en      = 1'b0;
        mem_wr_en      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            lru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_rd_en  = ({28'd0, process_id} < 32'(PROCESSES));
                    state_next = lru_pkg::ST_LOOKUP;
                end
            end
            lru_pkg::ST_LOOKUP:
            begin
                mem_wr_en     = proc_ok && page_ok;
                red_ctrl.load = 1'b1;
                search_next   = need_search;
                step_cnt_next = '0;
                if (proc_ok)
                begin
                    tick_next = tick_reg + 1'b1;
                end
                state_next = need_search ? lru_pkg::ST_REDUCE : lru_pkg::ST_EMIT;
            end
            lru_pkg::ST_REDUCE:
            begin
                red_ctrl.step = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_W'(LEVELS - 1))
                begin
                    state_next = lru_pkg::ST_EMIT;
                end
            end
            lru_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lru_pkg::ST_IDLE;
            tick_reg      <= 32'd1;
            step_cnt_reg  <= '0;
            search_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            step_cnt_reg  <= step_cnt_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pid_reg   <= process_id;
            pc_reg    <= program_counter;
            limit_reg <= pages_in_use;
            map_reg   <= resident_map;
            free_reg  <= frame_free;
        end
        if (load_out)
        begin
            want_out_reg   <= want_full[lru_pkg::PAGE_W-1:0];
            miss_out_reg   <= miss;
            evict_out_reg  <= search_reg && best_valid;
            victim_out_reg <= (search_reg && best_valid) ?
                              lru_pkg::PAGE_W'(best_index) : '0;
        end
    end

    lru_stamp_mem #(
        .ROWS  (PROCESSES),
        .PAGES (PAGES_PER_PROCESS)
    ) u_stamp_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_row  (ROW_W'(process_id)),
        .rd_data (rd_data),
        .wr_en   (mem_wr_en),
        .wr_row  (ROW_W'(pid_reg)),
        .wr_data (wr_data)
    );

    lru_age_reduce #(
        .PAGES (PAGES_PER_PROCESS)
    ) u_age_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (red_ctrl),
        .elig_in    (elig),
        .age_in     (ages),
        .best_valid (best_valid),
        .best_index (best_index)
    );

    assign out_valid   = out_valid_reg;
    assign wanted_page = want_out_reg;
    assign page_miss   = miss_out_reg;
    assign evict_valid = evict_out_reg;
    assign victim_page = victim_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evict_valid |-> page_miss)
        else $error("eviction reported on a hit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evict_valid |-> victim_page == '0)
        else $error("victim page not cleared without eviction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lru_pkg::ST_LOOKUP) && proc_ok |=> tick_reg == $past(tick_reg) + 1'b1)
        else $error("tick did not advance by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lru_pkg::ST_LOOKUP) && !in_ready)
        else $error("accepted beat did not start a lookup");

endmodule
